/* rtl/core/dle_pkg.sv */
// shared constants and types of the dns label encoder
package dle_pkg;

  localparam int unsigned MAX_LABEL = 63;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned ADDR_W    = LEN_W + 1;
  localparam int unsigned MEM_DEPTH = 2 ** ADDR_W;
  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned Q_PTR_W   = 1;
  localparam int unsigned Q_CNT_W   = 2;

  localparam logic [7:0]       DOT_CHAR = 8'h2E;
  localparam logic             OP_CHAR  = 1'b0;
  localparam logic             OP_END   = 1'b1;
  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_LABEL);

  // one flushed label waiting for replay
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             ovf;
    logic             done;
    logic             bank;
  } cmd_t;

  // label buffer write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

endpackage

/* rtl/core/dle_if.sv */
// handshake channels of the dns label encoder
interface dle_in_if import dle_pkg::*; ;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] ch;

  modport source (output valid, output operation, output ch, input ready);
  modport sink (input valid, input operation, input ch, output ready);
endinterface

interface dle_out_if import dle_pkg::*; ;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_length;
  logic       last_of_run;
  logic       name_done;
  logic       label_overflow;

  modport source (output valid, output out_byte, output is_length, output last_of_run,
                  output name_done, output label_overflow, input ready);
  modport sink (input valid, input out_byte, input is_length, input last_of_run,
                input name_done, input label_overflow, output ready);
endinterface

/* rtl/core/dle_front.sv */
// front end: classifies words, buffers label characters, issues flush commands
module dle_front import dle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic       operation_i,
  input  logic [7:0] ch_i,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o,
  output wr_t        wr_o
);

  logic [LEN_W-1:0] fill_q, fill_d;
  logic             ovf_q, ovf_d;
  logic             bank_q, bank_d;
  logic             acc;
  logic             is_flush;

  assign ready_o  = !q_full_i;
  assign acc      = valid_i && ready_o;
  assign is_flush = (operation_i == OP_END) || (ch_i == DOT_CHAR);

  always_comb begin
    fill_d       = fill_q;
    ovf_d        = ovf_q;
    bank_d       = bank_q;
    push_o       = 1'b0;
    cmd_o.len    = fill_q;
    cmd_o.ovf    = ovf_q;
    cmd_o.done   = (operation_i == OP_END);
    cmd_o.bank   = bank_q;
    wr_o.en      = 1'b0;
    wr_o.addr    = {bank_q, fill_q};
    wr_o.data    = ch_i;
    if (acc) begin
      if (is_flush) begin
        push_o = 1'b1;
        fill_d = '0;
        ovf_d  = 1'b0;
        bank_d = !bank_q;
      end else if (fill_q < LEN_MAX) begin
        wr_o.en = 1'b1;
        fill_d  = fill_q + LEN_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ovf_q  <= 1'b0;
      bank_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      ovf_q  <= ovf_d;
      bank_q <= bank_d;
    end
  end

endmodule

/* rtl/core/dle_queue.sv */
// two-entry command queue between front and back
module dle_queue import dle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t head_o,
  input  logic pop_i
);

  cmd_t               slot_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_q, rptr_q;
  logic [Q_CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + Q_PTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + Q_PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + Q_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - Q_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* rtl/core/dle_back.sv */
// back end: label buffer and replay of length byte and characters
module dle_back import dle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  wr_t        wr_i,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_length_o,
  output logic       last_of_run_o,
  output logic       name_done_o,
  output logic       label_overflow_o
);

  logic [7:0]       mem [MEM_DEPTH];
  logic [7:0]       rd_q;
  logic             phase_q, phase_d;
  logic [LEN_W-1:0] idx_q, idx_d;
  logic             valid_q, valid_d;
  logic [7:0]       byte_q, byte_d;
  logic             isl_q, isl_d;
  logic             last_q, last_d;
  logic             done_q, done_d;
  logic             ovf_q, ovf_d;
  logic             can_load;
  logic             last_char;

  assign can_load  = !valid_q || ready_i;
  assign last_char = (idx_q == cmd_i.len - LEN_W'(1));

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    valid_d = valid_q && !ready_i;
    byte_d  = byte_q;
    isl_d   = isl_q;
    last_d  = last_q;
    done_d  = done_q;
    ovf_d   = ovf_q;
    pop_o   = 1'b0;
    if (cmd_valid_i && can_load) begin
      valid_d = 1'b1;
      ovf_d   = cmd_i.ovf;
      if (!phase_q) begin
        byte_d = 8'(cmd_i.len);
        isl_d  = 1'b1;
        last_d = (cmd_i.len == '0);
        done_d = cmd_i.done && (cmd_i.len == '0);
        if (cmd_i.len == '0) begin
          pop_o = 1'b1;
        end else begin
          phase_d = 1'b1;
          idx_d   = '0;
        end
      end else begin
        byte_d = rd_q;
        isl_d  = 1'b0;
        last_d = last_char;
        done_d = cmd_i.done && last_char;
        if (last_char) begin
          pop_o   = 1'b1;
          phase_d = 1'b0;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + LEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_q <= mem[{cmd_i.bank, idx_d}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    isl_q  <= isl_d;
    last_q <= last_d;
    done_q <= done_d;
    ovf_q  <= ovf_d;
  end

  assign valid_o          = valid_q;
  assign out_byte_o       = byte_q;
  assign is_length_o      = isl_q;
  assign last_of_run_o    = last_q;
  assign name_done_o      = done_q;
  assign label_overflow_o = ovf_q;

endmodule

/* rtl/core/dns_label_encoder.sv */
// top level of the dns label encoder
//
//   channel  dir  modport  payload
//   in_i     in   sink     operation, ch
//   out_o    out  source   out_byte, is_length, last_of_run, name_done, label_overflow
//
// a character word is taken; a dot or end word flushes the label in the front,
// then the back replays the label at one output word per cycle while out_o is
// ready, set by the single read port of the label buffer.
// two label banks and a two-entry command queue let the front fill the next
// label while the back replays; the front stalls while both banks are pending.
// reset clears counters, queue and output valid; buffer contents need no reset.
module dns_label_encoder import dle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  dle_in_if.sink    in_i,
  dle_out_if.source out_o
);

  logic q_full;
  logic push;
  cmd_t cmd;
  wr_t  wr;
  logic head_valid;
  cmd_t head;
  logic pop;

  dle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_i.valid),
    .ready_o     (in_i.ready),
    .operation_i (in_i.operation),
    .ch_i        (in_i.ch),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (cmd),
    .wr_o        (wr)
  );

  dle_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (q_full),
    .valid_o (head_valid),
    .head_o  (head),
    .pop_i   (pop)
  );

  dle_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .wr_i             (wr),
    .cmd_valid_i      (head_valid),
    .cmd_i            (head),
    .pop_o            (pop),
    .valid_o          (out_o.valid),
    .ready_i          (out_o.ready),
    .out_byte_o       (out_o.out_byte),
    .is_length_o      (out_o.is_length),
    .last_of_run_o    (out_o.last_of_run),
    .name_done_o      (out_o.name_done),
    .label_overflow_o (out_o.label_overflow)
  );

endmodule

/* sim/dle_tb_pkg.sv */
// expected-word model and scoreboard for the dns label encoder testbench
package dle_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import dle_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_length;
    logic       last_of_run;
    logic       name_done;
    logic       label_overflow;
  } enc_word_t;

  function automatic string word_text(enc_word_t w);
    return $sformatf("byte %02h len %b last %b done %b ovf %b",
                     w.out_byte, w.is_length, w.last_of_run, w.name_done, w.label_overflow);
  endfunction

  class label_encoding_model;
    logic [7:0]  label_chars[$];
    logic        dropped_char;
    enc_word_t   expected_words[$];
    int unsigned mismatches;

    function new();
      dropped_char = 1'b0;
      mismatches   = 0;
    endfunction

    // length word, then the buffered characters
    function void flush_label(logic end_of_name);
      enc_word_t   w;
      int unsigned n;
      n = label_chars.size();
      w.out_byte       = 8'(n);
      w.is_length      = 1'b1;
      w.last_of_run    = (n == 0);
      w.name_done      = (n == 0) && end_of_name;
      w.label_overflow = dropped_char;
      expected_words.push_back(w);
      foreach (label_chars[i]) begin
        w.out_byte    = label_chars[i];
        w.is_length   = 1'b0;
        w.last_of_run = (i == n - 1);
        w.name_done   = (i == n - 1) && end_of_name;
        expected_words.push_back(w);
      end
      label_chars.delete();
      dropped_char = 1'b0;
    endfunction

    function void take_word(logic op, logic [7:0] c);
      if (op == OP_END) begin
        flush_label(1'b1);
      end else if (c == DOT_CHAR) begin
        flush_label(1'b0);
      end else if (label_chars.size() < MAX_LABEL) begin
        label_chars.push_back(c);
      end else begin
        dropped_char = 1'b1;
      end
    endfunction

    function void check_word(enc_word_t got);
      enc_word_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, actual %s", $time, word_text(got));
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: mismatch, expected %s, actual %s", $time, word_text(want),
                   word_text(got));
        end
      end
    endfunction
  endclass

endpackage

/* sim/testbench.sv */
// top-level testbench of the dns label encoder
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dle_pkg::*;
  import dle_tb_pkg::*;

  localparam int unsigned NUM_ITEMS    = 380;
  localparam int unsigned QUIET_AFTER  = 330;
  localparam int unsigned HOLD_AT      = 120;
  localparam int unsigned PAUSE_AT     = 240;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dle_in_if  in_if ();
  dle_out_if out_if ();

  dns_label_encoder uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  label_encoding_model sb;
  int unsigned         items_sent = 0;
  int unsigned         cycles     = 0;
  bit                  quiet      = 1'b0;
  bit                  hold_req   = 1'b0;

  always #5 clk_i = ~clk_i;

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.take_word(in_if.operation, in_if.ch);
      if (out_if.valid && out_if.ready) begin
        sb.check_word('{out_byte: out_if.out_byte, is_length: out_if.is_length,
                        last_of_run: out_if.last_of_run, name_done: out_if.name_done,
                        label_overflow: out_if.label_overflow});
      end
    end
  end

  // receiver: random stalls, one long hold-off
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic op, input logic [7:0] c);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.ch        <= c;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_words.size() != 0);
  endtask

  function automatic logic [7:0] label_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == DOT_CHAR);
    return c;
  endfunction

  task automatic send_name(input bit force_long);
    int unsigned labels;
    int unsigned len;
    labels = $urandom_range(1, 4);
    for (int l = 0; l < labels; l++) begin
      if (force_long && l == 0) len = $urandom_range(64, 70);
      else if ($urandom_range(0, 14) == 0) len = $urandom_range(60, 70);
      else if ($urandom_range(0, 9) == 0) len = 0;
      else len = $urandom_range(1, 12);
      repeat (len) send_word(OP_CHAR, label_char());
      if (l != labels - 1) send_word(OP_CHAR, DOT_CHAR);
    end
    // trailing dot gives an empty last label
    if ($urandom_range(0, 5) == 0) send_word(OP_CHAR, DOT_CHAR);
    send_word(OP_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_noise();
    send_word(($urandom_range(0, 3) == 0) ? OP_END : OP_CHAR,
              ($urandom_range(0, 3) == 0) ? DOT_CHAR : 8'($urandom_range(0, 255)));
  endtask

  initial begin
    bit first_name;
    bit hold_done;
    bit pause_done;
    first_name = 1'b1;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    in_if.valid     <= 1'b0;
    in_if.operation <= OP_CHAR;
    in_if.ch        <= 8'h00;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // empty labels from end and dot
    send_word(OP_END, 8'h00);
    send_word(OP_CHAR, DOT_CHAR);
    // nul and all-ones bytes are ordinary characters
    send_word(OP_CHAR, 8'h00);
    send_word(OP_CHAR, 8'hFF);
    send_word(OP_CHAR, DOT_CHAR);
    // end word ignores a dot in ch
    send_word(OP_CHAR, 8'h61);
    send_word(OP_END, DOT_CHAR);
    send_word(OP_CHAR, 8'h7F);
    send_word(OP_CHAR, 8'h80);
    send_word(OP_END, 8'hFF);
    // double dot, then trailing dot before end
    send_word(OP_CHAR, 8'h77);
    send_word(OP_CHAR, DOT_CHAR);
    send_word(OP_CHAR, DOT_CHAR);
    send_word(OP_CHAR, 8'h78);
    send_word(OP_CHAR, DOT_CHAR);
    send_word(OP_END, 8'h55);
    send_word(OP_CHAR, 8'h55);
    send_word(OP_CHAR, 8'hAA);
    send_word(OP_END, 8'hAA);

    while (items_sent < NUM_ITEMS) begin
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      if (!pause_done && items_sent >= PAUSE_AT) begin
        pause_done = 1'b1;
        wait_for_drain();
      end
      quiet = (items_sent >= QUIET_AFTER);
      if (first_name || $urandom_range(0, 99) < 85) begin
        send_name(first_name);
        first_name = 1'b0;
      end else begin
        send_noise();
      end
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/dle_pkg.sv
rtl/core/dle_if.sv
rtl/core/dle_front.sv
rtl/core/dle_queue.sv
rtl/core/dle_back.sv
rtl/core/dns_label_encoder.sv
sim/dle_tb_pkg.sv
sim/testbench.sv
